// File: hdl/aes_bd_pkg.sv
package aes_bd_pkg;

   localparam int NumRounds = 14;
   localparam int NumWords = 60;

   typedef enum logic [2:0] {
      REG_KEY_LENGTH_MODE = 3'd0,
      REG_KEY_BITS_0      = 3'd1,
      REG_KEY_BITS_1      = 3'd2,
      REG_KEY_BITS_2      = 3'd3,
      REG_KEY_BITS_3      = 3'd4
   } reg_index_type;

   typedef logic [0:15][7:0] block_type;
   typedef logic [0:255][7:0] byte_table_type;
   typedef logic [0:NumRounds][127:0] round_keys_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } req_type;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } rsp_type;

   typedef struct packed {
      logic active;
      logic last;
   } cell_ctrl_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
      end
      return p;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] base;
      logic [7:0] e;
      r = 8'h01;
      base = x;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) r = gf_mul(r, base);
         base = gf_mul(base, base);
      end
      return r;
   endfunction

   function automatic logic [7:0] sbox_calc(input logic [7:0] x);
      logic [7:0] b;
      b = gf_inv(x);
      return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^
             {b[3:0], b[7:4]} ^ 8'h63;
   endfunction

   function automatic byte_table_type gen_fwd_table();
      byte_table_type t;
      for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
      return t;
   endfunction

   function automatic byte_table_type gen_inv_table();
      byte_table_type t;
      for (int i = 0; i < 256; i++) t[sbox_calc(8'(i))] = 8'(i);
      return t;
   endfunction

   localparam byte_table_type SboxFwd = gen_fwd_table();
   localparam byte_table_type SboxInv = gen_inv_table();

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SboxFwd[w[31:24]], SboxFwd[w[23:16]], SboxFwd[w[15:8]], SboxFwd[w[7:0]]};
   endfunction

endpackage

// File: hdl/aes_block_decrypt_unit.sv
// Channel   Ports                                  Direction  Handshake
// request   start, busy, req_data                  in         start high, busy low
// response  rsp_strobe, rsp_data                   out        strobe, one cycle
// config    psel, penable, pwrite, paddr, pwdata,  in/out     APB, pready tied high
//           prdata, pready
//
// One word is accepted every cycle while busy is low; each plaintext passes
// through the input key stage register and the chain of 14 round cells.
// Reset and every key register write start the key schedule, one round-key
// word per cycle: busy stays high through word 43, 51 or 59 for 128, 192, 256 bits.
// The receiver cannot stall, so the chain never holds a word.
module aes_block_decrypt_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  aes_bd_pkg::req_type  req_data,
   output logic                 rsp_strobe,
   output aes_bd_pkg::rsp_type  rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [5:0]           paddr,
   input  logic [63:0]          pwdata,
   output logic [63:0]          prdata,
   output logic                 pready
);
   import aes_bd_pkg::*;

   logic [1:0]       mode_ff, mode_in;
   logic [3:0][63:0] key_ff, key_in;
   logic             cfg_write;
   logic             key_start;
   logic [1:0]       key_sel;
   logic [4:0]       nr;
   logic             expand_busy;
   round_keys_type   round_keys;
   reg_index_type    reg_idx;

   logic      in_valid_ff;
   block_type in_state_ff, in_state_in;

   logic      [NumRounds:0] chain_valid;
   block_type [NumRounds:0] chain_state;

   assign pready = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign reg_idx = reg_index_type'(paddr[5:3]);

   always_comb begin
      mode_in = mode_ff;
      key_in = key_ff;
      key_start = 1'b0;
      if (cfg_write) begin
         case (reg_idx)
            REG_KEY_LENGTH_MODE: begin
               mode_in = pwdata[1:0];
               key_start = 1'b1;
            end
            REG_KEY_BITS_0: begin
               key_in[0] = pwdata;
               key_start = 1'b1;
            end
            REG_KEY_BITS_1: begin
               key_in[1] = pwdata;
               key_start = 1'b1;
            end
            REG_KEY_BITS_2: begin
               key_in[2] = pwdata;
               key_start = 1'b1;
            end
            REG_KEY_BITS_3: begin
               key_in[3] = pwdata;
               key_start = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEY_LENGTH_MODE: prdata = {62'h0, mode_ff};
         REG_KEY_BITS_0:      prdata = key_ff[0];
         REG_KEY_BITS_1:      prdata = key_ff[1];
         REG_KEY_BITS_2:      prdata = key_ff[2];
         REG_KEY_BITS_3:      prdata = key_ff[3];
         default:             prdata = 64'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
         key_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         key_ff <= key_in;
      end
   end

   // Mode three behaves as the 256-bit key.
   assign key_sel = (mode_ff == 2'd3) ? 2'd2 : mode_ff;
   assign nr = 5'd10 + {2'b00, key_sel, 1'b0};

   aes_bd_key_expand u_key_expand (
      .clock      (clock),
      .reset      (reset),
      .start      (key_start),
      .key_sel    (key_sel),
      .key        ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .busy       (expand_busy),
      .round_keys (round_keys)
   );

   assign busy = expand_busy;

   assign in_state_in = {req_data.cipher_high, req_data.cipher_low} ^ round_keys[nr[3:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_state_ff <= in_state_in;
   end

   assign chain_valid[0] = in_valid_ff;
   assign chain_state[0] = in_state_ff;

   // Cell j runs round 13 - j; the last cell runs round zero without mixing.
   for (genvar j = 0; j < NumRounds; j++) begin : g_cell
      cell_ctrl_type ctrl;
      assign ctrl.last = (j == NumRounds - 1);
      assign ctrl.active = (j == NumRounds - 1) || ({1'b0, 4'(j)} >= 5'(NumRounds) - nr);

      aes_bd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .round_key  (round_keys[NumRounds - 1 - j]),
         .valid_up   (chain_valid[j]),
         .state_up   (chain_state[j]),
         .valid_down (chain_valid[j + 1]),
         .state_down (chain_state[j + 1])
      );
   end

   assign rsp_strobe = chain_valid[NumRounds];
   assign rsp_data = rsp_type'(chain_state[NumRounds]);

endmodule

// File: hdl/aes_bd_key_expand.sv
module aes_bd_key_expand (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               key_sel,
   input  logic [255:0]             key,
   output logic                     busy,
   output aes_bd_pkg::round_keys_type round_keys
);
   import aes_bd_pkg::*;

   logic                       load_ff, load_in;
   logic                       run_ff, run_in;
   logic [5:0]                 idx_ff, idx_in;
   logic [2:0]                 phase_ff, phase_in;
   logic [7:0]                 rcon_ff, rcon_in;
   logic [0:7][31:0]           win_ff, win_in;
   logic [NumWords-1:0][31:0]  words_ff, words_in;

   logic [3:0] nk;
   logic [5:0] last_idx;
   logic [31:0] temp;
   logic [31:0] new_word;
   logic [3:0] src;

   assign nk = 4'd4 + {1'b0, key_sel, 1'b0};
   assign last_idx = {nk, 2'b00} + 6'd27;

   always_comb begin
      temp = win_ff[0];
      if (phase_ff == 3'd0) begin
         temp = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && phase_ff == 3'd4) begin
         temp = sub_word(win_ff[0]);
      end
      new_word = win_ff[3'(nk - 4'd1)] ^ temp;
   end

   always_comb begin
      load_in = load_ff;
      run_in = run_ff;
      idx_in = idx_ff;
      phase_in = phase_ff;
      rcon_in = rcon_ff;
      win_in = win_ff;
      words_in = words_ff;
      src = 4'd0;
      if (start) begin
         load_in = 1'b1;
         run_in = 1'b0;
      end else if (load_ff) begin
         load_in = 1'b0;
         run_in = 1'b1;
         idx_in = {2'b00, nk};
         phase_in = 3'd0;
         rcon_in = 8'h01;
         for (int k = 0; k < 8; k++) begin
            words_in[k] = key[255 - 32 * k -: 32];
            src = nk - 4'd1 - 4'(k);
            win_in[k] = (4'(k) < nk) ? key[255 - 32 * src[2:0] -: 32] : 32'h0;
         end
      end else if (run_ff) begin
         words_in[idx_ff] = new_word;
         win_in[0] = new_word;
         for (int k = 1; k < 8; k++) win_in[k] = win_ff[k - 1];
         if (phase_ff == 3'd0) rcon_in = gf_mul(rcon_ff, 8'h02);
         phase_in = ({1'b0, phase_ff} == nk - 4'd1) ? 3'd0 : phase_ff + 3'd1;
         idx_in = idx_ff + 6'd1;
         if (idx_ff == last_idx) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b1;
         run_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         run_ff <= run_in;
      end
      idx_ff <= idx_in;
      phase_ff <= phase_in;
      rcon_ff <= rcon_in;
      win_ff <= win_in;
      words_ff <= words_in;
   end

   assign busy = load_ff | run_ff;

   always_comb begin
      for (int r = 0; r <= NumRounds; r++) begin
         round_keys[r] = {words_ff[4 * r], words_ff[4 * r + 1],
                          words_ff[4 * r + 2], words_ff[4 * r + 3]};
      end
   end

endmodule

// File: hdl/aes_bd_cell.sv
module aes_bd_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  aes_bd_pkg::cell_ctrl_type  ctrl,
   input  logic [127:0]               round_key,
   input  logic                       valid_up,
   input  aes_bd_pkg::block_type      state_up,
   output logic                       valid_down,
   output aes_bd_pkg::block_type      state_down
);
   import aes_bd_pkg::*;

   logic      valid_ff;
   block_type state_ff, state_in;
   block_type shifted, subbed, keyed, mixed;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shifted[4 * ((c + r) % 4) + r] = state_up[4 * c + r];
         end
      end
      for (int j = 0; j < 16; j++) subbed[j] = SboxInv[shifted[j]];
      keyed = subbed ^ round_key;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            mixed[4 * c + r] = gf_mul(8'h0e, keyed[4 * c + r]) ^
                               gf_mul(8'h0b, keyed[4 * c + (r + 1) % 4]) ^
                               gf_mul(8'h0d, keyed[4 * c + (r + 2) % 4]) ^
                               gf_mul(8'h09, keyed[4 * c + (r + 3) % 4]);
         end
      end
      // Cells ahead of the first round of a shorter key pass the word through.
      if (!ctrl.active) state_in = state_up;
      else if (ctrl.last) state_in = keyed;
      else state_in = mixed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_up;
      end
      state_ff <= state_in;
   end

   assign valid_down = valid_ff;
   assign state_down = state_ff;

endmodule
